@@ src/lcar_pkg.sv @@
// ============================================================================
// lcar_pkg
// Shared types and constants of the load cell converter reader.
// ============================================================================
package lcar_pkg;

    localparam int DATA_BITS_DEF    = 24;
    localparam int EXTRA_PULSES_DEF = 1;

    localparam int ALIGN_BITS  = 32;
    localparam int HALF_W      = 16;
    localparam int SETTLE_W    = 16;
    localparam int RAW_W       = 24;
    localparam int NET_W       = 34;
    localparam int CAL_W       = 48;
    localparam int TILT_W      = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;

    // 78125 / 2^32 grams per aligned count, in Q.16: c * 78125 / 2^16
    localparam logic [16:0] WEIGHT_MUL = 17'd78125;

    localparam logic [HALF_W-1:0]   HALF_PERIOD_RST = 16'd50;
    localparam logic [SETTLE_W-1:0] SETTLE_RST      = 16'd250;
    localparam logic [NET_W-1:0]    INTERCEPT_RST   = '0;
    localparam logic [TILT_W-1:0]   TILT_RST        = 24'd65536;

    localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
    localparam logic [1:0] REG_SETTLE      = 2'd1;
    localparam logic [1:0] REG_INTERCEPT   = 2'd2;
    localparam logic [1:0] REG_TILT        = 2'd3;

    typedef struct packed {
        logic                  clk_level;
        logic                  conv;
        logic                  tare;
        logic [ALIGN_BITS-1:0] aligned;
    } tick_t;

    typedef struct packed {
        logic [HALF_W-1:0]   half_period;
        logic [SETTLE_W-1:0] settle;
    } timing_t;

    typedef struct packed {
        logic signed [NET_W-1:0] intercept;
        logic [TILT_W-1:0]       tilt;
    } cal_t;

endpackage

@@ src/lcar_front.sv @@
// ============================================================================
// lcar_front
// Serial clock pulse sequencer: one tick per transfer, shifts in the reading.
// ============================================================================
module lcar_front #(
    parameter int DATA_BITS    = lcar_pkg::DATA_BITS_DEF,
    parameter int EXTRA_PULSES = lcar_pkg::EXTRA_PULSES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              dout_level,
    input  lcar_pkg::timing_t timing,
    output lcar_pkg::tick_t   entry
);

    localparam int PULSES = DATA_BITS + EXTRA_PULSES;
    localparam int BC_W   = $clog2(PULSES + 1);
    localparam logic [DATA_BITS-1:0] MSB_MASK = {1'b1, {(DATA_BITS-1){1'b0}}};

    localparam logic [2:0] PH_PWR_HIGH = 3'd0;
    localparam logic [2:0] PH_PWR_LOW  = 3'd1;
    localparam logic [2:0] PH_WAIT     = 3'd2;
    localparam logic [2:0] PH_SETTLE   = 3'd3;
    localparam logic [2:0] PH_HIGH     = 3'd4;
    localparam logic [2:0] PH_LOW      = 3'd5;

    logic [2:0]                   phase_reg, phase_next;
    logic [lcar_pkg::HALF_W-1:0]  tick_reg, tick_next;
    logic [BC_W-1:0]              bit_reg, bit_next;
    logic [DATA_BITS-1:0]         shift_reg, shift_next;
    logic                         tare_taken_reg, tare_taken_next;

    logic [lcar_pkg::HALF_W-1:0]  hp;
    logic [lcar_pkg::HALF_W:0]    tick_inc;
    logic                         hp_done;
    logic                         settle_done;
    logic [BC_W-1:0]              bit_inc;
    logic [DATA_BITS-1:0]         shift_new;
    logic [DATA_BITS-1:0]         count;

    always_comb
    begin
        hp          = (timing.half_period == '0) ? lcar_pkg::HALF_W'(1) : timing.half_period;
        tick_inc    = {1'b0, tick_reg} + (lcar_pkg::HALF_W+1)'(1);
        hp_done     = tick_inc >= {1'b0, hp};
        settle_done = tick_inc >= {1'b0, timing.settle};
        bit_inc     = bit_reg + BC_W'(1);
        shift_new   = (bit_reg < BC_W'(DATA_BITS))
                    ? {shift_reg[DATA_BITS-2:0], dout_level} : shift_reg;
        count       = shift_new ^ MSB_MASK;
    end

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_next        = bit_reg;
        shift_next      = shift_reg;
        tare_taken_next = tare_taken_reg;
        entry           = '0;
        unique case (phase_reg)
            PH_PWR_HIGH:
            begin
                entry.clk_level = 1'b1;
                tick_next       = tick_inc[lcar_pkg::HALF_W-1:0];
                if (hp_done)
                begin
                    phase_next = PH_PWR_LOW;
                    tick_next  = '0;
                end
            end
            PH_PWR_LOW:
            begin
                tick_next = tick_inc[lcar_pkg::HALF_W-1:0];
                if (hp_done)
                begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end
            end
            PH_WAIT:
            begin
                if (!dout_level)
                begin
                    tick_next  = '0;
                    phase_next = (timing.settle != '0) ? PH_SETTLE : PH_HIGH;
                end
            end
            PH_SETTLE:
            begin
                tick_next = tick_inc[lcar_pkg::HALF_W-1:0];
                if (settle_done)
                begin
                    phase_next = PH_HIGH;
                    tick_next  = '0;
                end
            end
            PH_HIGH:
            begin
                entry.clk_level = 1'b1;
                tick_next       = tick_inc[lcar_pkg::HALF_W-1:0];
                if (hp_done)
                begin
                    phase_next = PH_LOW;
                    tick_next  = '0;
                end
            end
            PH_LOW:
            begin
                tick_next = tick_inc[lcar_pkg::HALF_W-1:0];
                if (hp_done)
                begin
                    tick_next  = '0;
                    shift_next = shift_new;
                    bit_next   = bit_inc;
                    phase_next = PH_HIGH;
                    if (bit_inc >= BC_W'(PULSES))
                    begin
                        entry.conv      = 1'b1;
                        entry.tare      = !tare_taken_reg;
                        entry.aligned   = lcar_pkg::ALIGN_BITS'(count)
                                        << (lcar_pkg::ALIGN_BITS - DATA_BITS);
                        tare_taken_next = 1'b1;
                        shift_next      = '0;
                        bit_next        = '0;
                        phase_next      = PH_WAIT;
                    end
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                tick_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_PWR_HIGH;
            tick_reg       <= '0;
            bit_reg        <= '0;
            shift_reg      <= '0;
            tare_taken_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_reg        <= bit_next;
            shift_reg      <= shift_next;
            tare_taken_reg <= tare_taken_next;
        end
    end

endmodule

@@ src/lcar_queue.sv @@
// ============================================================================
// lcar_queue
// Short tick queue between the pulse sequencer and the scaling unit.
// ============================================================================
module lcar_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lcar_pkg::tick_t wr_entry,
    input  logic            rd_en,
    output lcar_pkg::tick_t rd_entry,
    output logic            full,
    output logic            not_empty
);

    localparam int DEPTH = lcar_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcar_pkg::tick_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign rd_entry  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

@@ src/lcar_back.sv @@
// ============================================================================
// lcar_back
// Scaling unit: weight, tare, net and calibrated value, plus the result slot.
// ============================================================================
module lcar_back #(
    parameter int DATA_BITS = lcar_pkg::DATA_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                entry_ready,
    input  lcar_pkg::tick_t                     entry,
    output logic                                entry_take,
    input  lcar_pkg::cal_t                      cal,
    input  logic                                pop,
    output logic                                empty,
    output logic                                clock_out,
    output logic                                sample_valid,
    output logic [lcar_pkg::RAW_W-1:0]          raw_count,
    output logic signed [lcar_pkg::NET_W-1:0]   net_grams,
    output logic signed [lcar_pkg::CAL_W-1:0]   calibrated_grams
);

    localparam int NET_W  = lcar_pkg::NET_W;
    localparam int DIFF_W = NET_W + 2;
    localparam int PART_W = DIFF_W + 13;
    localparam int PROD_W = 60;
    localparam int MULW_W = lcar_pkg::ALIGN_BITS + 17;
    localparam int W_W    = NET_W - 1;

    localparam logic [2:0] ST_PROD   = 3'd0;
    localparam logic [2:0] ST_WEIGHT = 3'd1;
    localparam logic [2:0] ST_NET    = 3'd2;
    localparam logic [2:0] ST_DIFF   = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic                                 busy_reg;
    logic [2:0]                           step_reg;
    logic                                 out_valid_reg;
    logic signed [NET_W-1:0]              tare_reg;

    logic                                 clk_lvl_reg;
    logic                                 tare_flag_reg;
    logic [lcar_pkg::ALIGN_BITS-1:0]      aligned_reg;
    logic [MULW_W-1:0]                    prod_reg;
    logic [W_W-1:0]                       w_reg;
    logic signed [NET_W-1:0]              net_reg;
    logic signed [DIFF_W-1:0]             d_reg;
    logic signed [PART_W-1:0]             pl_reg;
    logic signed [PART_W-1:0]             ph_reg;
    logic signed [PROD_W-1:0]             p_reg;

    logic                                 clk_out_reg;
    logic                                 valid_out_reg;
    logic [lcar_pkg::RAW_W-1:0]           raw_out_reg;
    logic signed [NET_W-1:0]              net_out_reg;
    logic signed [lcar_pkg::CAL_W-1:0]    cal_out_reg;

    logic                                 out_free;
    logic                                 finish;
    logic [MULW_W-1:0]                    prod_rnd;
    logic signed [PROD_W:0]               p_sum;
    logic signed [PROD_W-1:0]             q_sum;
    logic signed [lcar_pkg::CAL_W-1:0]    cal_value;
    logic [lcar_pkg::RAW_W-1:0]           raw_value;

    always_comb
    begin
        out_free   = !out_valid_reg || pop;
        entry_take = entry_ready && !busy_reg && out_free;
        finish     = busy_reg && (step_reg == ST_OUT) && out_free;
        prod_rnd   = prod_reg + MULW_W'(32768);
        p_sum      = ((PROD_W+1)'(ph_reg) <<< 12) + (PROD_W+1)'(pl_reg);
        q_sum      = p_reg + PROD_W'(32768);
        // the rounded product stays within 44 bits, so no clipping is reached
        cal_value  = lcar_pkg::CAL_W'($signed(q_sum[PROD_W-1:16]));
        raw_value  = lcar_pkg::RAW_W'(aligned_reg >> (lcar_pkg::ALIGN_BITS - DATA_BITS));
    end

    assign empty            = !out_valid_reg;
    assign clock_out        = clk_out_reg;
    assign sample_valid     = valid_out_reg;
    assign raw_count        = raw_out_reg;
    assign net_grams        = net_out_reg;
    assign calibrated_grams = cal_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= ST_PROD;
            out_valid_reg <= 1'b0;
            tare_reg      <= '0;
        end
        else
        begin
            if (entry_take && entry.conv)
            begin
                busy_reg <= 1'b1;
                step_reg <= ST_PROD;
            end
            else if (finish)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && step_reg != ST_OUT)
            begin
                step_reg <= step_reg + 3'd1;
            end

            if (busy_reg && step_reg == ST_NET && tare_flag_reg)
            begin
                tare_reg <= $signed({1'b0, w_reg});
            end

            if ((entry_take && !entry.conv) || finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (entry_take)
        begin
            clk_lvl_reg   <= entry.clk_level;
            tare_flag_reg <= entry.tare;
            aligned_reg   <= entry.aligned;
        end

        if (busy_reg)
        begin
            unique case (step_reg)
                ST_PROD:   prod_reg <= MULW_W'(aligned_reg) * MULW_W'(lcar_pkg::WEIGHT_MUL);
                ST_WEIGHT: w_reg    <= prod_rnd[MULW_W-1:16];
                ST_NET:    net_reg  <= $signed({1'b0, w_reg}) - tare_reg;
                ST_DIFF:   d_reg    <= DIFF_W'(net_reg) - DIFF_W'(cal.intercept);
                ST_MUL:
                begin
                    pl_reg <= PART_W'(d_reg) * PART_W'($signed({1'b0, cal.tilt[11:0]}));
                    ph_reg <= PART_W'(d_reg) * PART_W'($signed({1'b0, cal.tilt[23:12]}));
                end
                ST_SUM:    p_reg    <= p_sum[PROD_W-1:0];
                default:
                begin
                end
            endcase
        end

        if (entry_take && !entry.conv)
        begin
            clk_out_reg   <= entry.clk_level;
            valid_out_reg <= 1'b0;
            raw_out_reg   <= '0;
            net_out_reg   <= '0;
            cal_out_reg   <= '0;
        end
        else if (finish)
        begin
            clk_out_reg   <= clk_lvl_reg;
            valid_out_reg <= !tare_flag_reg;
            raw_out_reg   <= tare_flag_reg ? '0 : raw_value;
            net_out_reg   <= tare_flag_reg ? '0 : net_reg;
            cal_out_reg   <= tare_flag_reg ? '0 : cal_value;
        end
    end

endmodule

@@ src/load_cell_adc_reader_scale_core.sv @@
// ============================================================================
// load_cell_adc_reader_scale_core
// Load cell serial converter reader with tare and linear calibration.
// ============================================================================
// Each transfer in is one tick of the serial timing and gives exactly one result
// transfer out, in order. The pulse sequencer takes one tick per cycle while full
// is low. A tick that completes a conversion goes through the scaling unit in
// order (weight multiply, round, net, intercept, two partial tilt products, sum
// and round); ticks behind it wait in a four-entry queue, and full rises once
// that queue is used up. While pop is held the rate is one tick per cycle between
// conversions; no tick is taken during a conversion. The first conversion after
// reset sets the tare and is reported with sample_valid low.
module load_cell_adc_reader_scale_core #(
    parameter int DATA_BITS    = lcar_pkg::DATA_BITS_DEF,
    parameter int EXTRA_PULSES = lcar_pkg::EXTRA_PULSES_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   dout_level,
    output logic                                   empty,
    input  logic                                   pop,
    output logic                                   clock_out,
    output logic                                   sample_valid,
    output logic [lcar_pkg::RAW_W-1:0]             raw_count,
    output logic signed [lcar_pkg::NET_W-1:0]      net_grams,
    output logic signed [lcar_pkg::CAL_W-1:0]      calibrated_grams,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [lcar_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [lcar_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [lcar_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                   pready
);

    logic [lcar_pkg::HALF_W-1:0]        half_period_reg;
    logic [lcar_pkg::SETTLE_W-1:0]      settle_reg;
    logic signed [lcar_pkg::NET_W-1:0]  intercept_reg;
    logic [lcar_pkg::TILT_W-1:0]        tilt_reg;

    logic                cfg_write;
    logic [1:0]          reg_sel;
    logic                advance;
    lcar_pkg::tick_t     front_entry;
    lcar_pkg::tick_t     head_entry;
    logic                head_ready;
    logic                head_take;
    lcar_pkg::timing_t   timing;
    lcar_pkg::cal_t      cal;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;
    assign advance   = push && !full;

    assign timing.half_period = half_period_reg;
    assign timing.settle      = settle_reg;
    assign cal.intercept      = intercept_reg;
    assign cal.tilt           = tilt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= lcar_pkg::HALF_PERIOD_RST;
            settle_reg      <= lcar_pkg::SETTLE_RST;
            intercept_reg   <= lcar_pkg::INTERCEPT_RST;
            tilt_reg        <= lcar_pkg::TILT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                lcar_pkg::REG_HALF_PERIOD: half_period_reg <= pwdata[lcar_pkg::HALF_W-1:0];
                lcar_pkg::REG_SETTLE:      settle_reg      <= pwdata[lcar_pkg::SETTLE_W-1:0];
                lcar_pkg::REG_INTERCEPT:   intercept_reg   <= pwdata[lcar_pkg::NET_W-1:0];
                lcar_pkg::REG_TILT:        tilt_reg        <= pwdata[lcar_pkg::TILT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            lcar_pkg::REG_HALF_PERIOD: prdata = lcar_pkg::APB_DATA_W'(half_period_reg);
            lcar_pkg::REG_SETTLE:      prdata = lcar_pkg::APB_DATA_W'(settle_reg);
            lcar_pkg::REG_INTERCEPT:   prdata = lcar_pkg::APB_DATA_W'(intercept_reg);
            lcar_pkg::REG_TILT:        prdata = lcar_pkg::APB_DATA_W'(tilt_reg);
            default:                   prdata = '0;
        endcase
    end

    lcar_front #(
        .DATA_BITS    (DATA_BITS),
        .EXTRA_PULSES (EXTRA_PULSES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .dout_level (dout_level),
        .timing     (timing),
        .entry      (front_entry)
    );

    lcar_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (advance),
        .wr_entry  (front_entry),
        .rd_en     (head_take),
        .rd_entry  (head_entry),
        .full      (full),
        .not_empty (head_ready)
    );

    lcar_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .entry_ready      (head_ready),
        .entry            (head_entry),
        .entry_take       (head_take),
        .cal              (cal),
        .pop              (pop),
        .empty            (empty),
        .clock_out        (clock_out),
        .sample_valid     (sample_valid),
        .raw_count        (raw_count),
        .net_grams        (net_grams),
        .calibrated_grams (calibrated_grams)
    );

endmodule

@@ sim/load_cell_adc_reader_scale_core_tb.sv @@
// ============================================================================
// load_cell_adc_reader_scale_core_tb
// Feeds converter data line ticks and register writes into the reader,
// predicts the clock level and scaled reading of every tick, and checks each
// result transfer in order against that prediction.
// ============================================================================
module load_cell_adc_reader_scale_core_tb;

    localparam int CONV_BITS   = lcar_pkg::DATA_BITS_DEF;
    localparam int TAIL_PULSES = lcar_pkg::EXTRA_PULSES_DEF;

    localparam int RAW_W      = lcar_pkg::RAW_W;
    localparam int NET_W      = lcar_pkg::NET_W;
    localparam int CAL_W      = lcar_pkg::CAL_W;
    localparam int TILT_W     = lcar_pkg::TILT_W;
    localparam int HALF_W     = lcar_pkg::HALF_W;
    localparam int SETTLE_W   = lcar_pkg::SETTLE_W;
    localparam int ALIGN_BITS = lcar_pkg::ALIGN_BITS;
    localparam int APB_ADDR_W = lcar_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = lcar_pkg::APB_DATA_W;

    localparam logic [NET_W-1:0] ICPT_MIN = {1'b1, {(NET_W-1){1'b0}}};
    localparam logic [NET_W-1:0] ICPT_MAX = {1'b0, {(NET_W-1){1'b1}}};
    localparam logic [TILT_W-1:0] TILT_MAX = {TILT_W{1'b1}};

    typedef enum logic [2:0] {
        SEQ_PWR_HIGH,
        SEQ_PWR_LOW,
        SEQ_WAIT,
        SEQ_SETTLE,
        SEQ_HIGH,
        SEQ_LOW
    } seq_phase_t;

    typedef struct packed {
        logic             clk_lvl;
        logic             valid;
        logic [RAW_W-1:0] raw;
        logic [NET_W-1:0] net;
        logic [CAL_W-1:0] cal;
    } tick_result_t;

    class scale_scoreboard;
        logic [HALF_W-1:0]       half_period;
        logic [SETTLE_W-1:0]     settle;
        logic signed [NET_W-1:0] intercept;
        logic [TILT_W-1:0]       tilt;
        seq_phase_t              seq_phase;
        int unsigned             tick_cnt;
        int unsigned             bit_cnt;
        logic [RAW_W-1:0]        shift;
        longint                  tare;
        bit                      tare_taken;
        tick_result_t            expected_q[$];
        int                      mismatches;
        int                      checked;
        int                      conversions;

        function new();
            half_period = lcar_pkg::HALF_PERIOD_RST;
            settle      = lcar_pkg::SETTLE_RST;
            intercept   = lcar_pkg::INTERCEPT_RST;
            tilt        = lcar_pkg::TILT_RST;
            seq_phase   = SEQ_PWR_HIGH;
            tick_cnt    = 0;
            bit_cnt     = 0;
            shift       = '0;
            tare        = 0;
            tare_taken  = 0;
            mismatches  = 0;
            checked     = 0;
            conversions = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
            case (idx)
                lcar_pkg::REG_HALF_PERIOD: half_period = value[HALF_W-1:0];
                lcar_pkg::REG_SETTLE:      settle      = value[SETTLE_W-1:0];
                lcar_pkg::REG_INTERCEPT:   intercept   = value[NET_W-1:0];
                lcar_pkg::REG_TILT:        tilt        = value[TILT_W-1:0];
                default:         ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // grams in Q.16 from the offset-binary count
        function longint weight_q16(logic [RAW_W-1:0] count);
            logic [63:0] c;
            c = 64'(count) << (ALIGN_BITS - CONV_BITS);
            return longint'((c * 64'd78125 + 64'd32768) >> 16);
        endfunction

        function logic [CAL_W-1:0] calibrated(longint net);
            longint diff;
            longint prod;
            longint q;
            longint cal_max;
            longint cal_min;
            cal_max = (64'sd1 <<< (CAL_W - 1)) - 1;
            cal_min = -(64'sd1 <<< (CAL_W - 1));
            diff = net - longint'(intercept);
            prod = diff * longint'(tilt);
            q = (prod + 64'sd32768) >>> 16;
            if (q > cal_max)
                q = cal_max;
            else if (q < cal_min)
                q = cal_min;
            return q[CAL_W-1:0];
        endfunction

        function void note_tick(logic d);
            tick_result_t r;
            int unsigned  hp;
            logic [RAW_W-1:0] count;
            longint w;
            longint net;
            r = '0;
            hp = (half_period == 0) ? 1 : half_period;
            case (seq_phase)
                SEQ_PWR_HIGH:
                begin
                    r.clk_lvl = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= hp)
                    begin
                        seq_phase = SEQ_PWR_LOW;
                        tick_cnt = 0;
                    end
                end
                SEQ_PWR_LOW:
                begin
                    tick_cnt++;
                    if (tick_cnt >= hp)
                    begin
                        seq_phase = SEQ_WAIT;
                        tick_cnt = 0;
                    end
                end
                SEQ_WAIT:
                begin
                    if (d == 1'b0)
                    begin
                        tick_cnt = 0;
                        seq_phase = (settle != 0) ? SEQ_SETTLE : SEQ_HIGH;
                    end
                end
                SEQ_SETTLE:
                begin
                    tick_cnt++;
                    if (tick_cnt >= settle)
                    begin
                        seq_phase = SEQ_HIGH;
                        tick_cnt = 0;
                    end
                end
                SEQ_HIGH:
                begin
                    r.clk_lvl = 1'b1;
                    tick_cnt++;
                    if (tick_cnt >= hp)
                    begin
                        seq_phase = SEQ_LOW;
                        tick_cnt = 0;
                    end
                end
                default:
                begin
                    tick_cnt++;
                    if (tick_cnt >= hp)
                    begin
                        tick_cnt = 0;
                        if (bit_cnt < CONV_BITS)
                            shift = {shift[RAW_W-2:0], d};
                        bit_cnt++;
                        if (bit_cnt >= CONV_BITS + TAIL_PULSES)
                        begin
                            count = shift ^ (RAW_W'(1) << (CONV_BITS - 1));
                            w = weight_q16(count);
                            conversions++;
                            if (!tare_taken)
                            begin
                                tare = w;
                                tare_taken = 1;
                            end
                            else
                            begin
                                net = w - tare;
                                r.valid = 1'b1;
                                r.raw = count;
                                r.net = net[NET_W-1:0];
                                r.cal = calibrated(net);
                            end
                            shift = '0;
                            bit_cnt = 0;
                            seq_phase = SEQ_WAIT;
                        end
                        else
                            seq_phase = SEQ_HIGH;
                    end
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [63:0] e, logic [63:0] a);
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h", checked, field, e, a);
        endfunction

        function void check_tick(tick_result_t got);
            tick_result_t e;
            checked++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: unexpected transfer", checked);
                return;
            end
            e = expected_q.pop_front();
            if (got.clk_lvl !== e.clk_lvl) report("clock_out", e.clk_lvl, got.clk_lvl);
            if (got.valid !== e.valid)     report("sample_valid", e.valid, got.valid);
            if (got.raw !== e.raw)         report("raw_count", e.raw, got.raw);
            if (got.net !== e.net)         report("net_grams", e.net, got.net);
            if (got.cal !== e.cal)         report("calibrated_grams", e.cal, got.cal);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  dout_level = 1'b1;
    logic                  empty;
    logic                  pop = 1'b0;
    logic                  clock_out;
    logic                  sample_valid;
    logic [RAW_W-1:0]      raw_count;
    logic [NET_W-1:0]      net_grams;
    logic [CAL_W-1:0]      calibrated_grams;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    scale_scoreboard  sb;
    bit               tx_idle_en = 1;
    bit               rx_idle_en = 1;
    int               rx_hold = 0;
    int               items_sent = 0;
    int               wait_low_pct = 30;
    logic [RAW_W-1:0] data_word = '0;

    load_cell_adc_reader_scale_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .dout_level       (dout_level),
        .empty            (empty),
        .pop              (pop),
        .clock_out        (clock_out),
        .sample_valid     (sample_valid),
        .raw_count        (raw_count),
        .net_grams        (net_grams),
        .calibrated_grams (calibrated_grams),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 clk = ~clk;

    // result side: random stalls and a counted hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            pop <= 1'b0;
            rx_hold = rx_hold - 1;
        end
        else
            pop <= !(rx_idle_en && $urandom_range(0, 99) < 36);
    end

    always @(posedge clk)
    begin
        tick_result_t got;
        if (rst_n && pop && !empty)
        begin
            got.clk_lvl = clock_out;
            got.valid   = sample_valid;
            got.raw     = raw_count;
            got.net     = net_grams;
            got.cal     = calibrated_grams;
            sb.check_tick(got);
        end
    end

    function automatic logic [RAW_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return RAW_W'(1) << (CONV_BITS - 1);
            3:       return (RAW_W'(1) << (CONV_BITS - 1)) - 1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // data line level that keeps the conversion sequence going
    function automatic logic next_dout();
        int unsigned hp;
        hp = (sb.half_period == 0) ? 1 : sb.half_period;
        case (sb.seq_phase)
            SEQ_WAIT:
            begin
                data_word = pick_word();
                return ($urandom_range(0, 99) < wait_low_pct) ? 1'b0 : 1'b1;
            end
            SEQ_LOW:
            begin
                if (sb.tick_cnt + 1 >= hp && sb.bit_cnt < CONV_BITS)
                    return data_word[CONV_BITS - 1 - sb.bit_cnt];
                return 1'($urandom_range(0, 1));
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_tick();
        logic d;
        @(negedge clk);
        while (tx_idle_en && $urandom_range(0, 99) < 36)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        d = next_dout();
        push <= 1'b1;
        dout_level <= d;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_tick(d);
        items_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_register(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int               target;
        logic [31:0]      r;
        logic [NET_W-1:0] icpt;
        logic [TILT_W-1:0] tl;
        logic [HALF_W-1:0] hpv;
        logic [SETTLE_W-1:0] stv;

        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // power-up pulse at reset timing, then register changes mid-phase
        repeat (20) send_tick();
        wait_idle();
        write_reg(lcar_pkg::REG_HALF_PERIOD, 64'(16'hFFFF));
        repeat (5) send_tick();
        wait_idle();
        write_reg(lcar_pkg::REG_HALF_PERIOD, 64'd0);
        write_reg(lcar_pkg::REG_SETTLE, 64'(16'hFFFF));
        wait_low_pct = 100;
        while (sb.seq_phase != SEQ_SETTLE)
            send_tick();
        repeat (3) send_tick();
        wait_idle();
        write_reg(lcar_pkg::REG_SETTLE, 64'd0);
        // tare conversion
        while (sb.conversions < 1)
            send_tick();

        for (int ph = 0; items_sent < 1800; ph++)
        begin
            wait_idle();
            hpv = ($urandom_range(0, 9) < 7) ? 16'd1 : 16'($urandom_range(0, 4));
            case ($urandom_range(0, 2))
                0:       stv = 16'd0;
                1:       stv = 16'd1;
                default: stv = 16'($urandom_range(2, 6));
            endcase
            r = $urandom;
            case (ph)
                0:
                begin
                    icpt = ICPT_MIN;
                    tl = TILT_MAX;
                end
                1:
                begin
                    icpt = ICPT_MAX;
                    tl = TILT_MAX;
                end
                2:
                begin
                    icpt = '0;
                    tl = '0;
                end
                default:
                begin
                    case ($urandom_range(0, 4))
                        0:       icpt = ICPT_MIN;
                        1:       icpt = ICPT_MAX;
                        2:       icpt = '0;
                        3:       icpt = NET_W'({$urandom, $urandom});
                        default: icpt = {{(NET_W-18){r[17]}}, r[17:0]};
                    endcase
                    case ($urandom_range(0, 3))
                        0:       tl = '0;
                        1:       tl = TILT_MAX;
                        2:       tl = lcar_pkg::TILT_RST;
                        default: tl = TILT_W'($urandom);
                    endcase
                end
            endcase
            write_reg(lcar_pkg::REG_HALF_PERIOD, 64'(hpv));
            write_reg(lcar_pkg::REG_SETTLE, 64'(stv));
            write_reg(lcar_pkg::REG_INTERCEPT, 64'(icpt));
            write_reg(lcar_pkg::REG_TILT, 64'(tl));

            tx_idle_en = (ph != 1);
            rx_idle_en = (ph != 1);
            if (ph == 2)
                rx_hold = 300;
            wait_low_pct = $urandom_range(5, 60);
            target = sb.conversions + 3;
            while (sb.conversions < target)
                send_tick();
        end

        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
